### design/button_beep_screen_controller_defines.svh
// assertion macros used by the checker file
`ifndef BUTTON_BEEP_SCREEN_CONTROLLER_DEFINES_SVH
`define BUTTON_BEEP_SCREEN_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BBSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbsc assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BBSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbsc assertion failed");

`endif

### design/bbsc_pkg.sv
`default_nettype none

package bbsc_pkg;

  localparam int unsigned PressW = 14;
  localparam int unsigned AwakeW = 16;
  localparam int unsigned BeepW  = 8;
  localparam int unsigned CfgW   = 16;

  localparam logic [PressW-1:0] PRESS_SAT     = 14'd10000;
  localparam logic [BeepW-1:0]  DOUBLE_TICKS  = 8'd150;
  localparam logic [BeepW-1:0]  DOUBLE_GAP_LO = 8'd50;
  localparam logic [BeepW-1:0]  DOUBLE_GAP_HI = 8'd100;

  localparam logic [AwakeW-1:0] AWAKE_RST      = 16'd6000;
  localparam logic [PressW-1:0] LONG_PRESS_RST = 14'd100;
  localparam logic [BeepW-1:0]  SHORT_BEEP_RST = 8'd7;
  localparam logic [BeepW-1:0]  LONG_BEEP_RST  = 8'd200;

  localparam logic [1:0] SCREEN_1 = 2'd1;
  localparam logic [1:0] SCREEN_2 = 2'd2;
  localparam logic [1:0] SCREEN_3 = 2'd3;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_SUPPLY = 2'd1,
    REQ_LOAD   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    BEEP_NONE   = 2'd0,
    BEEP_SINGLE = 2'd1,
    BEEP_DOUBLE = 2'd2,
    BEEP_LONG   = 2'd3
  } beep_e;

  typedef enum logic [1:0] {
    PRESS_NONE  = 2'd0,
    PRESS_SHORT = 2'd1,
    PRESS_LONG  = 2'd2
  } press_e;

  typedef enum logic [1:0] {
    CFG_AWAKE      = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_SHORT_BEEP = 2'd2,
    CFG_LONG_BEEP  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [AwakeW-1:0] awake_ticks;
    logic [PressW-1:0] long_press_ticks;
    logic [BeepW-1:0]  short_beep_ticks;
    logic [BeepW-1:0]  long_beep_ticks;
  } cfg_t;

  typedef struct packed {
    logic [PressW-1:0] press_count;
    logic [AwakeW-1:0] awake_left;
    logic [1:0]        screen;
    beep_e             beep_kind;
    logic [BeepW-1:0]  beep_left;
    logic              buzzer;
  } state_t;

  typedef struct packed {
    logic       buzzer_on;
    logic [1:0] screen_sel;
    logic       display_awake;
    press_e     press_event;
  } result_t;

endpackage

`default_nettype wire

### design/bbsc_step.sv
`default_nettype none

module bbsc_step (
  input  bbsc_pkg::cfg_t    cfg_i,
  input  bbsc_pkg::state_t  cur_i,
  input  bbsc_pkg::req_e    req_i,
  input  logic              button_i,
  input  logic              supply_i,
  output bbsc_pkg::state_t  nxt_o,
  output bbsc_pkg::result_t res_o
);

  logic [bbsc_pkg::PressW-1:0] pc1;
  logic                        was_on;
  logic                        sound;
  bbsc_pkg::press_e            evt;
  bbsc_pkg::state_t            nxt;

  always_comb begin
    nxt    = cur_i;
    pc1    = cur_i.press_count;
    was_on = cur_i.buzzer;
    sound  = 1'b0;
    evt    = bbsc_pkg::PRESS_NONE;
    case (req_i)
      bbsc_pkg::REQ_TICK: begin
        if (button_i && (cur_i.press_count < bbsc_pkg::PRESS_SAT)) begin
          pc1 = cur_i.press_count + 14'd1;
        end
        nxt.press_count = pc1;
        // release after a held press
        if ((pc1 != '0) && !button_i) begin
          nxt.beep_kind = bbsc_pkg::BEEP_SINGLE;
          nxt.beep_left = cfg_i.short_beep_ticks;
          if (pc1 > cfg_i.long_press_ticks) begin
            if (cur_i.awake_left != '0) begin
              nxt.screen = bbsc_pkg::SCREEN_3;
            end
            evt = bbsc_pkg::PRESS_LONG;
          end else begin
            if (cur_i.awake_left != '0) begin
              nxt.screen = (cur_i.screen != bbsc_pkg::SCREEN_1) ? bbsc_pkg::SCREEN_1
                                                                 : bbsc_pkg::SCREEN_2;
            end
            evt = bbsc_pkg::PRESS_SHORT;
          end
          nxt.awake_left  = cfg_i.awake_ticks;
          nxt.press_count = '0;
        end
        if (nxt.awake_left != '0) begin
          nxt.awake_left = nxt.awake_left - 16'd1;
        end
        // beep sequencer, tests buzzer level from before this tick
        sound = (nxt.beep_kind == bbsc_pkg::BEEP_SINGLE) ||
                (nxt.beep_kind == bbsc_pkg::BEEP_LONG) ||
                ((nxt.beep_kind == bbsc_pkg::BEEP_DOUBLE) && (nxt.beep_left != '0) &&
                 (nxt.beep_left < bbsc_pkg::DOUBLE_GAP_LO)) ||
                (nxt.beep_left > bbsc_pkg::DOUBLE_GAP_HI);
        if (sound && (nxt.beep_left != '0) && !was_on) begin
          nxt.buzzer = 1'b1;
        end
        if ((nxt.beep_kind == bbsc_pkg::BEEP_DOUBLE) &&
            (nxt.beep_left >= bbsc_pkg::DOUBLE_GAP_LO) &&
            (nxt.beep_left < bbsc_pkg::DOUBLE_GAP_HI) && was_on) begin
          nxt.buzzer = 1'b0;
        end
        if (nxt.beep_left != '0) begin
          nxt.beep_left = nxt.beep_left - 8'd1;
        end
        if (nxt.beep_left == '0) begin
          nxt.beep_kind = bbsc_pkg::BEEP_NONE;
        end
        if ((nxt.beep_kind == bbsc_pkg::BEEP_NONE) && (nxt.beep_left == '0) && was_on) begin
          nxt.buzzer = 1'b0;
        end
      end
      bbsc_pkg::REQ_SUPPLY: begin
        nxt.awake_left = cfg_i.awake_ticks;
        if (supply_i) begin
          nxt.beep_kind = bbsc_pkg::BEEP_DOUBLE;
          nxt.beep_left = bbsc_pkg::DOUBLE_TICKS;
        end else begin
          nxt.beep_kind = bbsc_pkg::BEEP_LONG;
          nxt.beep_left = cfg_i.long_beep_ticks;
        end
      end
      bbsc_pkg::REQ_LOAD: begin
        nxt.awake_left = cfg_i.awake_ticks;
      end
      default: begin
      end
    endcase
  end

  assign nxt_o               = nxt;
  assign res_o.buzzer_on     = nxt.buzzer;
  assign res_o.screen_sel    = nxt.screen;
  assign res_o.display_awake = (nxt.awake_left != '0);
  assign res_o.press_event   = evt;

endmodule

`default_nettype wire

### design/button_beep_screen_controller.sv
// button, beep and screen controller
// input channel (in_valid_i / in_stall_o) carries one beat per 10 ms tick or
// per supply/load event: req_type_i, button_level_i, supply_present_i.
// output channel (out_valid_o / out_stall_i) returns exactly one result beat
// per input beat: buzzer level, selected screen, display awake flag and the
// press classification of a release on that tick.
// configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 awake ticks, 1 long press ticks, 2 short beep ticks, 3 long beep ticks).
// path: an accepted beat lands in the input register, then its result moves
// into the result register, from which the receiver takes it.
// throughput: one beat per cycle unless the receiver stalls, set by the single
// pass through the next state logic between input register and result register.
// when the receiver stalls the result holds; one more beat can wait in the
// input register, after that in_stall_o rises until the output drains.
// reset clears the pipeline valids, the controller state (screen 1, display
// asleep, buzzer off, no beep) and loads the register defaults.
`default_nettype none

module button_beep_screen_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [bbsc_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic       button_level_i,
  input  logic       supply_present_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       buzzer_on_o,
  output logic [1:0] screen_sel_o,
  output logic       display_awake_o,
  output logic [1:0] press_event_o
);

  bbsc_pkg::cfg_t    cfg_q;
  bbsc_pkg::state_t  st_q;
  bbsc_pkg::state_t  st_d;
  bbsc_pkg::result_t res_q;
  bbsc_pkg::result_t res_d;

  logic           s1_vld_q;
  bbsc_pkg::req_e s1_req_q;
  logic           s1_button_q;
  logic           s1_supply_q;
  logic           out_vld_q;
  logic           adv;
  logic           in_acc;

  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = s1_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.awake_ticks      <= bbsc_pkg::AWAKE_RST;
      cfg_q.long_press_ticks <= bbsc_pkg::LONG_PRESS_RST;
      cfg_q.short_beep_ticks <= bbsc_pkg::SHORT_BEEP_RST;
      cfg_q.long_beep_ticks  <= bbsc_pkg::LONG_BEEP_RST;
    end else if (cfg_we_i) begin
      case (bbsc_pkg::cfg_idx_e'(cfg_idx_i))
        bbsc_pkg::CFG_AWAKE:      cfg_q.awake_ticks      <= cfg_wdata_i;
        bbsc_pkg::CFG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_wdata_i[13:0];
        bbsc_pkg::CFG_SHORT_BEEP: cfg_q.short_beep_ticks <= cfg_wdata_i[7:0];
        bbsc_pkg::CFG_LONG_BEEP:  cfg_q.long_beep_ticks  <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv || !s1_vld_q) begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q    <= bbsc_pkg::req_e'(req_type_i);
      s1_button_q <= button_level_i;
      s1_supply_q <= supply_present_i;
    end
  end

  bbsc_step u_step (
    .cfg_i    (cfg_q),
    .cur_i    (st_q),
    .req_i    (s1_req_q),
    .button_i (s1_button_q),
    .supply_i (s1_supply_q),
    .nxt_o    (st_d),
    .res_o    (res_d)
  );

  // state commits when the beat moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.press_count <= '0;
      st_q.awake_left  <= '0;
      st_q.screen      <= bbsc_pkg::SCREEN_1;
      st_q.beep_kind   <= bbsc_pkg::BEEP_NONE;
      st_q.beep_left   <= '0;
      st_q.buzzer      <= 1'b0;
      out_vld_q        <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s1_vld_q;
      if (s1_vld_q) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign buzzer_on_o     = res_q.buzzer_on;
  assign screen_sel_o    = res_q.screen_sel;
  assign display_awake_o = res_q.display_awake;
  assign press_event_o   = res_q.press_event;

endmodule

`default_nettype wire

### design/bbsc_chk.sv
`default_nettype none

`include "button_beep_screen_controller_defines.svh"

module bbsc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        buzzer_on_o,
  input logic [1:0]  screen_sel_o,
  input logic        display_awake_o,
  input logic [1:0]  press_event_o
);

  // a stalled result beat stays and keeps its payload
  `BBSC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `BBSC_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i,
    $stable(buzzer_on_o) && $stable(screen_sel_o) &&
    $stable(display_awake_o) && $stable(press_event_o))

  // input only backs up behind a stalled full output
  `BBSC_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // screen of a valid result is always one of the three screens
  `BBSC_ASSERT_NOW(a_screen_range, out_valid_o,
    screen_sel_o == bbsc_pkg::SCREEN_1 || screen_sel_o == bbsc_pkg::SCREEN_2 ||
    screen_sel_o == bbsc_pkg::SCREEN_3)

  // press code is none, short or long
  `BBSC_ASSERT_NOW(a_press_code, out_valid_o,
    press_event_o == bbsc_pkg::PRESS_NONE || press_event_o == bbsc_pkg::PRESS_SHORT ||
    press_event_o == bbsc_pkg::PRESS_LONG)

endmodule

bind button_beep_screen_controller bbsc_chk u_bbsc_chk (.*);

`default_nettype wire
